>>> sv/vwsnap_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwsnap_pkg
// Shared types and constants of the vertex weld snap unit.
// ----------------------------------------------------------------------------
package vwsnap_pkg;

    localparam int POS_W         = 32;
    localparam int THRESH_W      = 31;
    localparam int MATCH_INDEX_W = 10;

    // 0.03 in unsigned Q15.16, truncated
    localparam logic [THRESH_W-1:0] THRESH_RESET = 31'd1966;

    // request kinds carried in the low tuser bit of the input beat
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

    localparam int POS_BITS = $bits(pos_t);

endpackage : vwsnap_pkg
`default_nettype wire

>>> sv/vwsnap_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwsnap_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vwsnap_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule : vwsnap_ram
`default_nettype wire

>>> sv/vwsnap_cmp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vwsnap_cmp
// Shared proximity unit: checks all three coordinates against the threshold.
// ----------------------------------------------------------------------------
module vwsnap_cmp
    import vwsnap_pkg::*;
(
    input  wire pos_t                  vertex,
    input  wire pos_t                  ref_pos,
    input  wire logic [THRESH_W-1:0]   thresh,
    output logic                       hit
);

    function automatic logic coord_near(
        input logic [POS_W-1:0]    a,
        input logic [POS_W-1:0]    b,
        input logic [THRESH_W-1:0] thr
    );
        logic [POS_W:0] diff;
        logic [POS_W:0] mag;
        diff = {a[POS_W-1], a} - {b[POS_W-1], b};
        mag  = diff[POS_W] ? (~diff + {{POS_W{1'b0}}, 1'b1}) : diff;
        return mag <= {{(POS_W + 1 - THRESH_W){1'b0}}, thr};
    endfunction

    // exact 33-bit differences, magnitude compared without saturation
    assign hit = coord_near(vertex.x, ref_pos.x, thresh)
              && coord_near(vertex.y, ref_pos.y, thresh)
              && coord_near(vertex.z, ref_pos.z, thresh);

endmodule : vwsnap_cmp
`default_nettype wire

>>> sv/vertex_weld_snap_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_weld_snap_unit
// Snaps query vertices onto the first stored reference within the threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_tvalid/s_tready/s_tdata/s_tuser. tuser[0] picks a
//   load (append a reference) or a query; tuser[1] on a load empties the table
//   first. Result beats leave on m_tvalid/m_tready/m_tdata/m_tuser.
//   A load that fits produces no result beat and leaves the unit
//   ready again in the next cycle. A load into a full table is dropped and
//   yields one beat with m_tuser (table_full) set and zeros in m_tdata.
//   A query scans the reference RAM one entry per cycle from index 0 and stops
//   at the first hit; the scan allows for the registered RAM read. The result
//   goes to the result register, then via the emit state to the output
//   register. The single RAM read port and the shared compare unit set that
//   rate. s_tready is high only while the sequencer is idle. The result
//   register decouples the output: the unit accepts the next beat while a
//   result waits; if a second result is ready before the first one is taken,
//   the sequencer holds it in the emit state until m_tready. The weld
//   threshold is to be written by weld_threshold_we/_wdata only while idle;
//   the unit does not enforce this. Reset empties the table, clears the
//   output valid and loads the threshold with about 0.03 in unsigned Q15.16.
//   The RAM itself needs no clearing pass.
// ----------------------------------------------------------------------------
module vertex_weld_snap_unit
    import vwsnap_pkg::*;
#(
    parameter int MAX_REFS = 1024
) (
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                s_tvalid,
    output logic                     s_tready,
    // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
    input  wire logic [95:0]         s_tdata,
    // [0] req_type, [1] restart_table
    input  wire logic [1:0]          s_tuser,

    output logic                     m_tvalid,
    input  wire logic                m_tready,
    // [31:0] out_x, [63:32] out_y, [95:64] out_z, [96] matched,
    // [106:97] match_index, [111:107] zero
    output logic      [111:0]        m_tdata,
    // [0] table_full
    output logic                     m_tuser,

    input  wire logic                weld_threshold_we,
    input  wire logic [THRESH_W-1:0] weld_threshold_wdata
);

    localparam int IDX_W = $clog2(MAX_REFS);
    localparam int CNT_W = $clog2(MAX_REFS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_REFS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    state_t                   state_reg, state_next;
    logic [THRESH_W-1:0]      thresh_reg, thresh_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [CNT_W-1:0]         issue_reg, issue_next;
    logic [IDX_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     rd_vld_reg, rd_vld_next;
    pos_t                     vtx_reg, vtx_next;

    pos_t                     res_pos_reg, res_pos_next;
    logic                     res_matched_reg, res_matched_next;
    logic [MATCH_INDEX_W-1:0] res_idx_reg, res_idx_next;
    logic                     res_full_reg, res_full_next;

    logic                     out_vld_reg, out_vld_next;
    pos_t                     out_pos_reg, out_pos_next;
    logic                     out_matched_reg, out_matched_next;
    logic [MATCH_INDEX_W-1:0] out_idx_reg, out_idx_next;
    logic                     out_full_reg, out_full_next;

    logic                     accept;
    logic                     is_load;
    logic                     restart;
    logic                     ram_we;
    logic [IDX_W-1:0]         ram_waddr;
    logic [IDX_W-1:0]         ram_raddr;
    logic [POS_BITS-1:0]      ram_rdata;
    pos_t                     ref_pos;
    logic                     hit;
    logic [IDX_W+MATCH_INDEX_W-1:0] idx_wide;

    vwsnap_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (MAX_REFS)
    ) u_ref_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ref_pos = pos_t'(ram_rdata);

    vwsnap_cmp u_cmp (
        .vertex  (vtx_reg),
        .ref_pos (ref_pos),
        .thresh  (thresh_reg),
        .hit     (hit)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_load  = (s_tuser[0] == REQ_LOAD);
    assign restart  = s_tuser[1];

    // low bits of the hit index, zero-extended when the table is narrow
    assign idx_wide  = {{MATCH_INDEX_W{1'b0}}, rd_idx_reg};
    assign ram_raddr = issue_reg[IDX_W-1:0];

    always_comb
    begin
        state_next       = state_reg;
        thresh_next      = weld_threshold_we ? weld_threshold_wdata : thresh_reg;
        cnt_next         = cnt_reg;
        issue_next       = issue_reg;
        rd_idx_next      = rd_idx_reg;
        rd_vld_next      = rd_vld_reg;
        vtx_next         = vtx_reg;
        res_pos_next     = res_pos_reg;
        res_matched_next = res_matched_reg;
        res_idx_next     = res_idx_reg;
        res_full_next    = res_full_reg;
        out_vld_next     = out_vld_reg && !m_tready;
        out_pos_next     = out_pos_reg;
        out_matched_next = out_matched_reg;
        out_idx_next     = out_idx_reg;
        out_full_next    = out_full_reg;
        ram_we           = 1'b0;
        ram_waddr        = restart ? '0 : cnt_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_load)
                    begin
                        if (!restart && (cnt_reg == MAX_CNT))
                        begin
                            // drop the load, report a full table
                            res_pos_next     = '0;
                            res_matched_next = 1'b0;
                            res_idx_next     = '0;
                            res_full_next    = 1'b1;
                            state_next       = ST_EMIT;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            cnt_next = (restart ? '0 : cnt_reg) + CNT_ONE;
                        end
                    end
                    else
                    begin
                        vtx_next    = pos_t'(s_tdata);
                        issue_next  = '0;
                        rd_vld_next = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // advance the read pointer while entries remain
                rd_vld_next = (issue_reg < cnt_reg);
                rd_idx_next = issue_reg[IDX_W-1:0];
                if (issue_reg < cnt_reg)
                begin
                    issue_next = issue_reg + CNT_ONE;
                end

                if (rd_vld_reg && hit)
                begin
                    res_pos_next     = ref_pos;
                    res_matched_next = 1'b1;
                    res_idx_next     = idx_wide[MATCH_INDEX_W-1:0];
                    res_full_next    = 1'b0;
                    rd_vld_next      = 1'b0;
                    state_next       = ST_EMIT;
                end
                else if (!rd_vld_reg && (issue_reg == cnt_reg))
                begin
                    // no reference close enough: pass the vertex through
                    res_pos_next     = vtx_reg;
                    res_matched_next = 1'b0;
                    res_idx_next     = '0;
                    res_full_next    = 1'b0;
                    state_next       = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                // hold until the output register is free
                if (!out_vld_reg || m_tready)
                begin
                    out_vld_next     = 1'b1;
                    out_pos_next     = res_pos_reg;
                    out_matched_next = res_matched_reg;
                    out_idx_next     = res_idx_reg;
                    out_full_next    = res_full_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            thresh_reg      <= THRESH_RESET;
            cnt_reg         <= '0;
            issue_reg       <= '0;
            rd_idx_reg      <= '0;
            rd_vld_reg      <= 1'b0;
            vtx_reg         <= '0;
            res_pos_reg     <= '0;
            res_matched_reg <= 1'b0;
            res_idx_reg     <= '0;
            res_full_reg    <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_pos_reg     <= '0;
            out_matched_reg <= 1'b0;
            out_idx_reg     <= '0;
            out_full_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            thresh_reg      <= thresh_next;
            cnt_reg         <= cnt_next;
            issue_reg       <= issue_next;
            rd_idx_reg      <= rd_idx_next;
            rd_vld_reg      <= rd_vld_next;
            vtx_reg         <= vtx_next;
            res_pos_reg     <= res_pos_next;
            res_matched_reg <= res_matched_next;
            res_idx_reg     <= res_idx_next;
            res_full_reg    <= res_full_next;
            out_vld_reg     <= out_vld_next;
            out_pos_reg     <= out_pos_next;
            out_matched_reg <= out_matched_next;
            out_idx_reg     <= out_idx_next;
            out_full_reg    <= out_full_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, out_idx_reg, out_matched_reg, out_pos_reg};
    assign m_tuser  = out_full_reg;

endmodule : vertex_weld_snap_unit
`default_nettype wire
